### hdl/rrt_pkg.sv
// shared constants and types for the received range tracker
package rrt_pkg;
  localparam int unsigned MaxRanges = 64;
  localparam int unsigned PosBits = 48;
  localparam int unsigned LenBits = 31;
  localparam int unsigned FsBits = 48;

  typedef enum logic [1:0] {
    KIND_RECORD = 2'd0,
    KIND_COVER  = 2'd1,
    KIND_NEXT   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;
endpackage

### hdl/received_range_tracker.sv
// received range tracker: sorted disjoint range table held in one memory
// throughput: one item at a time, one memory access a cycle; a waiting result
//   stalls the input until it is taken
// reset: synchronous active low; clears range count, completion flag and file size,
//   memory contents are not cleared and need no clearing pass
module received_range_tracker #(
  parameter int unsigned MAX_RANGES = rrt_pkg::MaxRanges,
  parameter int unsigned POS_BITS = rrt_pkg::PosBits
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_kind,
  input  logic [47:0]                 in_position,
  input  logic [30:0]                 in_length,
  input  logic                        in_to_end,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_covered,
  output logic [47:0]                 out_next_position,
  output logic                        out_complete,
  output logic                        out_overflow,
  output logic [6:0]                  out_ranges_held,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [47:0]                 cfg_file_size
);
  import rrt_pkg::*;

  localparam int unsigned IdxBits = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int unsigned CntBits = $clog2(MAX_RANGES + 1);
  localparam logic [47:0] PosMask = (POS_BITS >= 48) ? {48{1'b1}} :
                                    ({48{1'b1}} >> (48 - POS_BITS));

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_SCAN_CHK, S_HEAD, S_MERGE, S_MERGE_CHK,
    S_SHUP_RD, S_SHUP_WR, S_INS, S_SHDN_RD, S_SHDN_WR, S_DONE_RD, S_DONE, S_OUT
  } state_t;

  // one memory holding start and stop of each range
  logic [95:0] mem [MAX_RANGES];
  logic [95:0] rd_q;
  logic        mem_we;
  logic [IdxBits-1:0] mem_addr;
  logic [95:0] mem_wd;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wd;
    rd_q <= mem[mem_addr];
  end

  state_t state_r;
  logic [CntBits-1:0] count_r, i_r, lo_r, hi_r;
  logic done_r;
  logic [47:0] fs_r, s_r, e_r, qe_r, ns_r, ne_r;
  logic [1:0] kind_r;
  logic ovf_r, cov_r;
  logic [47:0] next_r;
  logic out_valid_r;

  wire [47:0] rs = rd_q[95:48] & PosMask;
  wire [47:0] re = rd_q[47:0] & PosMask;

  // saturating end of position+length
  logic [48:0] sum;
  logic [47:0] ein;
  always_comb begin
    sum = {1'b0, in_position & PosMask} + {18'd0, in_length};
    ein = (sum[48] || (sum[47:0] > PosMask)) ? PosMask : sum[47:0];
  end

  assign in_stall  = (state_r != S_IDLE) || out_valid_r;
  assign cfg_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    mem_we = 1'b0;
    mem_wd = rd_q;
    mem_addr = i_r[IdxBits-1:0];
    unique case (state_r)
      S_SHUP_WR: begin mem_we = 1'b1; mem_addr = IdxBits'(i_r - (hi_r - lo_r) + 1'b1); end
      S_HEAD:    begin mem_we = 1'b1; mem_wd = {ns_r, ne_r}; mem_addr = lo_r[IdxBits-1:0]; end
      S_INS:     begin mem_we = 1'b1; mem_wd = {s_r, e_r}; mem_addr = lo_r[IdxBits-1:0]; end
      S_SHDN_WR: begin mem_we = 1'b1; mem_addr = i_r[IdxBits-1:0]; end
      S_SHDN_RD: mem_addr = IdxBits'(i_r - 1'b1);
      S_DONE_RD: mem_addr = '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      done_r <= 1'b0;
      fs_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (cfg_valid) fs_r <= cfg_file_size;
          if (in_valid && !in_stall) begin
            kind_r <= in_kind;
            s_r <= in_position & PosMask;
            e_r <= ein;
            ns_r <= in_position & PosMask;
            ne_r <= ein;
            qe_r <= in_to_end ? fs_r : ((ein > fs_r) ? fs_r : ein);
            cov_r <= 1'b0;
            ovf_r <= 1'b0;
            next_r <= (in_kind == KIND_NEXT) ? (in_position & PosMask) : '0;
            i_r <= '0;
            state_r <= (in_kind == KIND_NONE) ? S_OUT : S_SCAN;
          end
        end
        S_SCAN: begin
          if (i_r >= count_r) begin
            if (kind_r == KIND_RECORD) begin
              lo_r <= i_r;
              hi_r <= i_r;
              state_r <= S_MERGE;
            end else state_r <= S_OUT;
          end else state_r <= S_SCAN_CHK;
        end
        S_SCAN_CHK: begin
          state_r <= S_SCAN;
          i_r <= i_r + 1'b1;
          unique case (kind_r)
            KIND_RECORD: if (re >= s_r) begin
              lo_r <= i_r; hi_r <= i_r; state_r <= S_MERGE_CHK;
            end
            KIND_COVER: if (s_r >= rs && qe_r <= re) begin
              cov_r <= 1'b1; state_r <= S_OUT;
            end
            default: if (s_r >= rs && s_r < re) begin
              next_r <= re; state_r <= S_OUT;
            end
          endcase
        end
        S_MERGE_CHK: begin
          state_r <= S_MERGE;
          if (rs <= e_r) begin
            if (rs < ns_r) ns_r <= rs;
            if (re > ne_r) ne_r <= re;
            hi_r <= hi_r + 1'b1;
            i_r <= hi_r + 1'b1;
          end else i_r <= count_r; // no later range can touch
        end
        S_MERGE: begin
          if (i_r < count_r) state_r <= S_MERGE_CHK;
          else if (hi_r != lo_r) state_r <= S_HEAD;
          else if (e_r == s_r) state_r <= S_DONE_RD;
          else if (count_r >= CntBits'(MAX_RANGES)) begin
            ovf_r <= 1'b1; state_r <= S_DONE_RD;
          end else begin
            i_r <= count_r; state_r <= S_SHDN_RD;
          end
        end
        S_HEAD: begin i_r <= hi_r; state_r <= S_SHUP_RD; end
        S_SHUP_RD: begin
          if (i_r >= count_r) begin
            count_r <= count_r - (hi_r - lo_r) + 1'b1;
            state_r <= S_DONE_RD;
          end else state_r <= S_SHUP_WR;
        end
        S_SHUP_WR: begin i_r <= i_r + 1'b1; state_r <= S_SHUP_RD; end
        S_SHDN_RD: begin
          if (i_r <= lo_r) state_r <= S_INS;
          else state_r <= S_SHDN_WR;
        end
        S_SHDN_WR: begin i_r <= i_r - 1'b1; state_r <= S_SHDN_RD; end
        S_INS: begin count_r <= count_r + 1'b1; state_r <= S_DONE_RD; end
        S_DONE_RD: state_r <= S_DONE;
        S_DONE: begin
          done_r <= (count_r == CntBits'(1)) && (rs == '0) && (re >= fs_r);
          state_r <= S_OUT;
        end
        S_OUT: begin
          out_valid_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_covered = cov_r;
  assign out_next_position = next_r;
  assign out_complete = done_r;
  assign out_overflow = ovf_r;
  assign out_ranges_held = 7'(count_r);

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntBits'(MAX_RANGES)) else $error("range count above table size");
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && ovf_r |-> count_r == CntBits'(MAX_RANGES)) else $error("overflow while not full");
  a_ovf_rec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && ovf_r |-> kind_r == KIND_RECORD) else $error("overflow on a query");
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready |-> state_r == S_IDLE) else $error("config taken while busy");
endmodule

### dv/received_range_tracker_tb.sv
// testbench for the received range tracker: range table predictor, scoreboard and stimulus
`timescale 1ns / 1ps

module received_range_tracker_tb;
  import rrt_pkg::*;

  localparam int unsigned IdleLimit = 20000;
  localparam logic [47:0] PosMax = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic        covered;
    logic [47:0] next_position;
    logic        complete;
    logic        overflow;
    logic [6:0]  ranges_held;
  } answer_t;

  class range_scoreboard;
    logic [47:0] lo_tab[MaxRanges];
    logic [47:0] hi_tab[MaxRanges];
    int unsigned held;
    logic        done;
    logic [47:0] fsize;
    answer_t     pending[$];
    int unsigned errors;

    function void clear();
      held = 0;
      done = 0;
      fsize = 0;
      pending.delete();
    endfunction

    function logic [47:0] sat_end(logic [47:0] p, logic [30:0] len);
      logic [48:0] e;
      e = {1'b0, p} + {18'd0, len};
      return e[48] ? PosMax : e[47:0];
    endfunction

    function logic add_range(logic [47:0] s, logic [47:0] e);
      int unsigned a, b, n, i;
      logic [47:0] ns, ne;
      a = 0;
      ns = s;
      ne = e;
      while (a < held && hi_tab[a] < s) a++;
      b = a;
      while (b < held && lo_tab[b] <= e) begin
        if (lo_tab[b] < ns) ns = lo_tab[b];
        if (hi_tab[b] > ne) ne = hi_tab[b];
        b++;
      end
      n = b - a;
      if (n == 0) begin
        if (e == s) return 0;
        if (held >= MaxRanges) return 1;
        for (i = held; i > a; i--) begin
          lo_tab[i] = lo_tab[i-1];
          hi_tab[i] = hi_tab[i-1];
        end
        lo_tab[a] = s;
        hi_tab[a] = e;
        held++;
        return 0;
      end
      lo_tab[a] = ns;
      hi_tab[a] = ne;
      for (i = b; i < held; i++) begin
        lo_tab[i-n+1] = lo_tab[i];
        hi_tab[i-n+1] = hi_tab[i];
      end
      held = held - n + 1;
      return 0;
    endfunction

    function void note_beat(kind_t k, logic [47:0] p, logic [30:0] len, logic te);
      answer_t r;
      logic [47:0] e;
      r = '0;
      case (k)
        KIND_RECORD: begin
          r.overflow = add_range(p, sat_end(p, len));
          done = held == 1 && lo_tab[0] == 0 && hi_tab[0] >= fsize;
        end
        KIND_COVER: begin
          e = te ? fsize : sat_end(p, len);
          if (e > fsize) e = fsize;
          for (int i = 0; i < held; i++)
            if (p >= lo_tab[i] && e <= hi_tab[i]) begin
              r.covered = 1;
              break;
            end
        end
        KIND_NEXT: begin
          r.next_position = p;
          for (int i = 0; i < held; i++)
            if (p >= lo_tab[i] && p < hi_tab[i]) begin
              r.next_position = hi_tab[i];
              break;
            end
        end
        default: ;
      endcase
      r.complete = done;
      r.ranges_held = held[6:0];
      pending.push_back(r);
    endfunction

    function void check_beat(answer_t got);
      answer_t w;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result beat %h", $realtime, got);
        errors++;
        return;
      end
      w = pending.pop_front();
      if (got.covered !== w.covered) begin
        $display("%0t: covered exp %0d got %0d", $realtime, w.covered, got.covered);
        errors++;
      end
      if (got.next_position !== w.next_position) begin
        $display("%0t: next_position exp %h got %h", $realtime, w.next_position,
                 got.next_position);
        errors++;
      end
      if (got.complete !== w.complete) begin
        $display("%0t: complete exp %0d got %0d", $realtime, w.complete, got.complete);
        errors++;
      end
      if (got.overflow !== w.overflow) begin
        $display("%0t: overflow exp %0d got %0d", $realtime, w.overflow, got.overflow);
        errors++;
      end
      if (got.ranges_held !== w.ranges_held) begin
        $display("%0t: ranges_held exp %0d got %0d", $realtime, w.ranges_held,
                 got.ranges_held);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] in_kind = '0;
  logic [47:0] in_position = '0;
  logic [30:0] in_length = '0;
  logic in_to_end = 0;
  logic out_valid;
  logic out_stall = 0;
  logic out_covered, out_complete, out_overflow;
  logic [47:0] out_next_position;
  logic [6:0] out_ranges_held;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [47:0] cfg_file_size = '0;

  range_scoreboard sb;
  int unsigned idle_cycles;
  int unsigned stall_cycle = 0;
  bit hold_off = 0;
  bit burst_gaps = 1;
  logic [47:0] span;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  received_range_tracker DUT (.*);

  // scoreboard and watchdog sample the handshakes at the edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        sb.note_beat(kind_t'(in_kind), in_position, in_length, in_to_end);
      if (out_valid && !out_stall)
        sb.check_beat({out_covered, out_next_position, out_complete, out_overflow,
                       out_ranges_held});
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // receiver stall pattern, with stall-free stretches and one long hold-off
  always @(posedge clk) begin
    int unsigned n;
    n = $urandom_range(0, 99);
    stall_cycle <= stall_cycle + 1;
    if (hold_off) out_stall <= 1;
    else if ((stall_cycle / 256) % 3 == 0) out_stall <= 0;
    else out_stall <= n < 30;
  end

  task automatic send(kind_t k, logic [47:0] p, logic [30:0] len, logic te);
    int unsigned gap;
    if (burst_gaps && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_kind <= k;
    in_position <= p;
    in_length <= len;
    in_to_end <= te;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (2 * MaxRanges + 10) @(posedge clk);
  endtask

  task automatic write_size(logic [47:0] v);
    cfg_valid <= 1;
    cfg_file_size <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    sb.fsize = v;
  endtask

  function automatic logic [47:0] rnd_pos(logic [47:0] lim);
    logic [47:0] r;
    r = 48'({$urandom, $urandom});
    return (lim == PosMax) ? r : r % (lim + 1);
  endfunction

  task automatic random_phase(int unsigned count, logic [47:0] lim, int unsigned maxlen);
    int unsigned sel;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 50)
        send(KIND_RECORD, rnd_pos(lim), 31'($urandom_range(0, maxlen)),
             1'($urandom_range(0, 1)));
      else if (sel < 72)
        send(KIND_COVER, rnd_pos(lim), 31'($urandom_range(0, maxlen)),
             1'($urandom_range(0, 1)));
      else if (sel < 94)
        send(KIND_NEXT, rnd_pos(lim), 31'($urandom_range(0, maxlen)),
             1'($urandom_range(0, 1)));
      else if (sel < 97)
        send(KIND_NONE, rnd_pos(PosMax), 31'($urandom), 1'($urandom_range(0, 1)));
      else
        send(KIND_RECORD, rnd_pos(PosMax), 31'($urandom), 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    sb.errors = 0;
    idle_cycles = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: empty table, extremes, unused kind
    write_size(48'd1000);
    send(KIND_COVER, 48'd0, 31'd10, 1'b0);
    send(KIND_NEXT, 48'd5, 31'd0, 1'b0);
    send(KIND_RECORD, 48'd100, 31'd0, 1'b0);
    send(KIND_RECORD, 48'd100, 31'd50, 1'b0);
    send(KIND_RECORD, 48'd150, 31'd0, 1'b0);
    send(KIND_RECORD, 48'd150, 31'd20, 1'b0);
    send(KIND_RECORD, 48'd300, 31'd100, 1'b0);
    send(KIND_RECORD, 48'd0, 31'd100, 1'b0);
    send(KIND_COVER, 48'd10, 31'd150, 1'b0);
    send(KIND_COVER, 48'd300, 31'd0, 1'b1);
    send(KIND_COVER, 48'd120, 31'h7FFF_FFFF, 1'b0);
    send(KIND_COVER, 48'd160, 31'd2, 1'b1);
    send(KIND_NEXT, 48'd170, 31'd0, 1'b0);
    send(KIND_NEXT, 48'd0, 31'd0, 1'b0);
    send(KIND_RECORD, 48'd150, 31'd900, 1'b0);
    send(KIND_COVER, 48'd0, 31'd0, 1'b1);
    send(KIND_NONE, PosMax, 31'h7FFF_FFFF, 1'b1);
    send(KIND_RECORD, PosMax - 5, 31'h7FFF_FFFF, 1'b0);
    send(KIND_NEXT, PosMax - 1, 31'd0, 1'b0);
    send(KIND_RECORD, 48'h5555_5555_5555, 31'h2AAA_AAAA, 1'b1);
    drain();

    // size change: completion only follows the next record
    write_size(48'd0);
    send(KIND_COVER, 48'd0, 31'd1, 1'b0);
    send(KIND_RECORD, 48'd0, 31'd0, 1'b0);
    drain();

    // table fill and overflow with isolated ranges
    write_size(PosMax);
    for (int i = 0; i < 70; i++)
      send(KIND_RECORD, 48'd1000 * 48'(i) + 48'd2000, 31'd10, 1'b0);
    random_phase(200, 48'd80000, 600);
    drain();

    // long receiver hold-off while items keep coming
    hold_off = 1;
    burst_gaps = 0;
    fork
      begin
        repeat (600) @(posedge clk);
        hold_off = 0;
      end
      random_phase(40, 48'd80000, 600);
    join
    burst_gaps = 1;
    drain();

    // small file, dense random traffic reaching completion
    write_size(48'd4000);
    random_phase(500, 48'd4200, 300);
    drain();
    write_size(48'd0);
    random_phase(150, 48'd200, 50);
    drain();

    // wide random positions and lengths
    write_size(PosMax);
    random_phase(400, PosMax, 32'h7FFF_FFFF);
    drain();
    span = 48'({$urandom, $urandom});
    write_size(span);
    random_phase(300, 48'd1000000, 200000);
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end
endmodule

### received_range_tracker.f
hdl/rrt_pkg.sv
hdl/received_range_tracker.sv
dv/received_range_tracker_tb.sv
